@@ rtl/clcd_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, constants and the microcode table of the 4-bit character LCD
// write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned WORD_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W  = 6;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_ON_WAIT = 3'd0,
    CFG_FUNCTION_SET  = 3'd1,
    CFG_ENTRY_MODE    = 3'd2,
    CFG_DISPLAY_ON    = 3'd3,
    CFG_SETTLE        = 3'd4,
    CFG_CLEAR_EXTRA   = 3'd5,
    CFG_ENABLE_PULSE  = 3'd6
  } cfg_idx_t;

  // register reset values
  localparam logic [HOLD_W-1:0] RST_POWER_ON_WAIT = 16'd30000;
  localparam logic [WORD_W-1:0] RST_FUNCTION_SET  = 8'h28;
  localparam logic [WORD_W-1:0] RST_ENTRY_MODE    = 8'h06;
  localparam logic [WORD_W-1:0] RST_DISPLAY_ON    = 8'h0f;
  localparam logic [HOLD_W-1:0] RST_SETTLE        = 16'd100;
  localparam logic [HOLD_W-1:0] RST_CLEAR_EXTRA   = 16'd3000;
  localparam logic [WORD_W-1:0] RST_ENABLE_PULSE  = 8'd1;

  localparam logic [HOLD_W-1:0] INIT_SLOW_WAIT_US = 16'd4100;
  localparam logic [WORD_W-1:0] CMD_DISPLAY_OFF   = 8'h08;
  localparam logic [WORD_W-1:0] CMD_CLEAR         = 8'h01;

  // operation codes
  typedef enum logic {
    OP_INIT  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // program entry points
  localparam logic [STEP_W-1:0] INIT_ENTRY  = 6'd0;
  localparam logic [STEP_W-1:0] WRITE_ENTRY = 6'd29;

  typedef enum logic [1:0] {
    NIB_CONST = 2'd0,
    NIB_HI    = 2'd1,
    NIB_LO    = 2'd2
  } nib_sel_t;

  typedef enum logic [2:0] {
    BYTE_IN    = 3'd0,
    BYTE_FSET  = 3'd1,
    BYTE_DOFF  = 3'd2,
    BYTE_CLR   = 3'd3,
    BYTE_ENTRY = 3'd4,
    BYTE_DON   = 3'd5
  } byte_sel_t;

  typedef enum logic [2:0] {
    HOLD_POWER  = 3'd0,
    HOLD_PULSE  = 3'd1,
    HOLD_SLOW   = 3'd2,
    HOLD_SETTLE = 3'd3,
    HOLD_CLEAR  = 3'd4
  } hold_sel_t;

  typedef struct packed {
    logic             en;
    nib_sel_t         nib_sel;
    logic [NIB_W-1:0] nib_const;
    byte_sel_t        byte_sel;
    hold_sel_t        hold_sel;
    logic             last;
  } ucode_t;

  function automatic ucode_t mk(input logic en, input nib_sel_t ns,
                                input logic [NIB_W-1:0] nc, input byte_sel_t bs,
                                input hold_sel_t hs, input logic last);
    ucode_t w;
    w.en        = en;
    w.nib_sel   = ns;
    w.nib_const = nc;
    w.byte_sel  = bs;
    w.hold_sel  = hs;
    w.last      = last;
    return w;
  endfunction

  // microcode: init runs steps 0..28, byte write runs 29..32
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = mk(1'b0, NIB_CONST, 4'h0, BYTE_IN, HOLD_POWER, 1'b1);
    unique case (step)
      6'd0:  w = mk(1'b0, NIB_CONST, 4'h0, BYTE_IN,    HOLD_POWER,  1'b0);
      6'd1:  w = mk(1'b1, NIB_CONST, 4'h3, BYTE_IN,    HOLD_PULSE,  1'b0);
      6'd2:  w = mk(1'b0, NIB_CONST, 4'h3, BYTE_IN,    HOLD_SLOW,   1'b0);
      6'd3:  w = mk(1'b1, NIB_CONST, 4'h3, BYTE_IN,    HOLD_PULSE,  1'b0);
      6'd4:  w = mk(1'b0, NIB_CONST, 4'h3, BYTE_IN,    HOLD_SETTLE, 1'b0);
      6'd5:  w = mk(1'b1, NIB_CONST, 4'h3, BYTE_IN,    HOLD_PULSE,  1'b0);
      6'd6:  w = mk(1'b0, NIB_CONST, 4'h3, BYTE_IN,    HOLD_SETTLE, 1'b0);
      6'd7:  w = mk(1'b1, NIB_CONST, 4'h2, BYTE_IN,    HOLD_PULSE,  1'b0);
      6'd8:  w = mk(1'b0, NIB_CONST, 4'h2, BYTE_IN,    HOLD_SETTLE, 1'b0);
      6'd9:  w = mk(1'b1, NIB_HI,    4'h0, BYTE_FSET,  HOLD_PULSE,  1'b0);
      6'd10: w = mk(1'b0, NIB_HI,    4'h0, BYTE_FSET,  HOLD_SETTLE, 1'b0);
      6'd11: w = mk(1'b1, NIB_LO,    4'h0, BYTE_FSET,  HOLD_PULSE,  1'b0);
      6'd12: w = mk(1'b0, NIB_LO,    4'h0, BYTE_FSET,  HOLD_SETTLE, 1'b0);
      6'd13: w = mk(1'b1, NIB_HI,    4'h0, BYTE_DOFF,  HOLD_PULSE,  1'b0);
      6'd14: w = mk(1'b0, NIB_HI,    4'h0, BYTE_DOFF,  HOLD_SETTLE, 1'b0);
      6'd15: w = mk(1'b1, NIB_LO,    4'h0, BYTE_DOFF,  HOLD_PULSE,  1'b0);
      6'd16: w = mk(1'b0, NIB_LO,    4'h0, BYTE_DOFF,  HOLD_SETTLE, 1'b0);
      6'd17: w = mk(1'b1, NIB_HI,    4'h0, BYTE_CLR,   HOLD_PULSE,  1'b0);
      6'd18: w = mk(1'b0, NIB_HI,    4'h0, BYTE_CLR,   HOLD_SETTLE, 1'b0);
      6'd19: w = mk(1'b1, NIB_LO,    4'h0, BYTE_CLR,   HOLD_PULSE,  1'b0);
      6'd20: w = mk(1'b0, NIB_LO,    4'h0, BYTE_CLR,   HOLD_CLEAR,  1'b0);
      6'd21: w = mk(1'b1, NIB_HI,    4'h0, BYTE_ENTRY, HOLD_PULSE,  1'b0);
      6'd22: w = mk(1'b0, NIB_HI,    4'h0, BYTE_ENTRY, HOLD_SETTLE, 1'b0);
      6'd23: w = mk(1'b1, NIB_LO,    4'h0, BYTE_ENTRY, HOLD_PULSE,  1'b0);
      6'd24: w = mk(1'b0, NIB_LO,    4'h0, BYTE_ENTRY, HOLD_SETTLE, 1'b0);
      6'd25: w = mk(1'b1, NIB_HI,    4'h0, BYTE_DON,   HOLD_PULSE,  1'b0);
      6'd26: w = mk(1'b0, NIB_HI,    4'h0, BYTE_DON,   HOLD_SETTLE, 1'b0);
      6'd27: w = mk(1'b1, NIB_LO,    4'h0, BYTE_DON,   HOLD_PULSE,  1'b0);
      6'd28: w = mk(1'b0, NIB_LO,    4'h0, BYTE_DON,   HOLD_SETTLE, 1'b1);
      6'd29: w = mk(1'b1, NIB_HI,    4'h0, BYTE_IN,    HOLD_PULSE,  1'b0);
      6'd30: w = mk(1'b0, NIB_HI,    4'h0, BYTE_IN,    HOLD_SETTLE, 1'b0);
      6'd31: w = mk(1'b1, NIB_LO,    4'h0, BYTE_IN,    HOLD_PULSE,  1'b0);
      6'd32: w = mk(1'b0, NIB_LO,    4'h0, BYTE_IN,    HOLD_SETTLE, 1'b1);
      default: w = mk(1'b0, NIB_CONST, 4'h0, BYTE_IN, HOLD_POWER, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/char_lcd_4bit_write_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_core
// Expands init and byte-write commands into LCD pin phases, driven by a
// microcode table with a step counter.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_*    | in  | tdata: data_byte, register_select; tuser: operation
//  out_*   | out | tdata: rs, enable, nibble, hold_us; tlast: last phase
//  cfg_*   | in  | write enable, register index, data
//
// One phase leaves per cycle while out_tready is high, set by the step counter
// walking the table. A byte write holds the sequencer for its accept plus four
// phases, init for its accept plus twenty-nine phases. A new item is taken the
// cycle after the last phase of the previous one is loaded into the output
// register. A stalled output holds the step counter. Reset restores the
// register defaults and idles the sequencer.
`default_nettype none

module char_lcd_4bit_write_sequencer_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [15:0]                     in_tdata,  // data_byte[7:0], register_select[8]
  input  wire  [0:0]                      in_tuser,  // operation
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [23:0]                     out_tdata, // rs[0], enable[1], nibble[5:2],
                                                     // hold_us[21:6]
  output logic                            out_tlast,
  input  wire                             cfg_we,
  input  wire  [clcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [clcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import clcd_pkg::*;

  // configuration registers
  logic [HOLD_W-1:0] power_on_wait_r;
  logic [WORD_W-1:0] function_set_r;
  logic [WORD_W-1:0] entry_mode_r;
  logic [WORD_W-1:0] display_on_r;
  logic [HOLD_W-1:0] settle_r;
  logic [HOLD_W-1:0] clear_extra_r;
  logic [WORD_W-1:0] enable_pulse_r;

  // sequencer
  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [WORD_W-1:0] byte_r;
  logic              rs_r;
  logic              in_acc;
  logic              advance;
  ucode_t            cw;

  // datapath
  logic [WORD_W-1:0] sel_byte;
  logic [NIB_W-1:0]  sel_nib;
  logic [HOLD_W-1:0] sel_hold;
  logic [HOLD_W:0]   clear_sum;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_rs_r, out_en_r, out_last_r;
  logic [NIB_W-1:0]  out_nib_r;
  logic [HOLD_W-1:0] out_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_wait_r <= RST_POWER_ON_WAIT;
      function_set_r  <= RST_FUNCTION_SET;
      entry_mode_r    <= RST_ENTRY_MODE;
      display_on_r    <= RST_DISPLAY_ON;
      settle_r        <= RST_SETTLE;
      clear_extra_r   <= RST_CLEAR_EXTRA;
      enable_pulse_r  <= RST_ENABLE_PULSE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POWER_ON_WAIT: power_on_wait_r <= cfg_wdata;
        CFG_FUNCTION_SET:  function_set_r  <= cfg_wdata[WORD_W-1:0];
        CFG_ENTRY_MODE:    entry_mode_r    <= cfg_wdata[WORD_W-1:0];
        CFG_DISPLAY_ON:    display_on_r    <= cfg_wdata[WORD_W-1:0];
        CFG_SETTLE:        settle_r        <= cfg_wdata;
        CFG_CLEAR_EXTRA:   clear_extra_r   <= cfg_wdata;
        CFG_ENABLE_PULSE:  enable_pulse_r  <= cfg_wdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && !busy_r;
  assign advance   = busy_r && (!out_valid_r || out_tready);
  assign cw        = ucode_rom(step_r);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      step_nxt = (in_tuser[0] == OP_WRITE) ? WRITE_ENTRY : INIT_ENTRY;
    end else if (advance) begin
      if (cw.last) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= INIT_ENTRY;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // init ignores the write fields, so rs is forced low there
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata[7:0];
      rs_r   <= in_tdata[8] && (in_tuser[0] == OP_WRITE);
    end
  end

  always_comb begin
    unique case (cw.byte_sel)
      BYTE_IN:    sel_byte = byte_r;
      BYTE_FSET:  sel_byte = function_set_r;
      BYTE_DOFF:  sel_byte = CMD_DISPLAY_OFF;
      BYTE_CLR:   sel_byte = CMD_CLEAR;
      BYTE_ENTRY: sel_byte = entry_mode_r;
      BYTE_DON:   sel_byte = display_on_r;
      default:    sel_byte = byte_r;
    endcase
  end

  always_comb begin
    unique case (cw.nib_sel)
      NIB_CONST: sel_nib = cw.nib_const;
      NIB_HI:    sel_nib = sel_byte[7:4];
      NIB_LO:    sel_nib = sel_byte[3:0];
      default:   sel_nib = cw.nib_const;
    endcase
  end

  assign clear_sum = {1'b0, settle_r} + {1'b0, clear_extra_r};

  always_comb begin
    unique case (cw.hold_sel)
      HOLD_POWER:  sel_hold = power_on_wait_r;
      HOLD_PULSE:  sel_hold = {{(HOLD_W-WORD_W){1'b0}}, enable_pulse_r};
      HOLD_SLOW:   sel_hold = INIT_SLOW_WAIT_US;
      HOLD_SETTLE: sel_hold = settle_r;
      HOLD_CLEAR:  sel_hold = clear_sum[HOLD_W] ? {HOLD_W{1'b1}} : clear_sum[HOLD_W-1:0];
      default:     sel_hold = settle_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rs_r   <= rs_r;
      out_en_r   <= cw.en;
      out_nib_r  <= sel_nib;
      out_hold_r <= sel_hold;
      out_last_r <= cw.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_hold_r, out_nib_r, out_en_r, out_rs_r};

endmodule

`default_nettype wire

@@ tb/clcd_phase_checker.sv @@
// ----------------------------------------------------------------------------
// clcd_phase_checker
// Watches the command, phase and register ports of the LCD write sequencer,
// expands each accepted command into the pin phases it should produce and
// compares every phase leaving the block, in order, field by field.
// ----------------------------------------------------------------------------
module clcd_phase_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  input  wire                             in_tready,
  input  wire  [15:0]                     in_tdata,  // data_byte[7:0], register_select[8]
  input  wire  [0:0]                      in_tuser,  // operation
  input  wire                             out_tvalid,
  input  wire                             out_tready,
  input  wire  [23:0]                     out_tdata, // rs[0], enable[1], nibble[5:2],
                                                     // hold_us[21:6]
  input  wire                             out_tlast,
  input  wire                             cfg_we,
  input  wire  [clcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [clcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     errors,
  output int unsigned                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam logic [NIB_W-1:0] WAKE_NIBBLE     = 4'h3;
  localparam logic [NIB_W-1:0] FOUR_BIT_NIBBLE = 4'h2;

  typedef struct packed {
    logic              rs;
    logic              en;
    logic [NIB_W-1:0]  nib;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } pin_phase_t;

  pin_phase_t phases_due[$];

  // shadow of the block's registers
  logic [HOLD_W-1:0] power_wait_r;
  logic [WORD_W-1:0] fset_word_r;
  logic [WORD_W-1:0] entry_word_r;
  logic [WORD_W-1:0] don_word_r;
  logic [HOLD_W-1:0] settle_r;
  logic [HOLD_W-1:0] clear_extra_r;
  logic [WORD_W-1:0] pulse_r;

  // hold arrives one bit wider so the clear settle can saturate
  function automatic void add_phase(input logic rs, input logic en,
                                    input logic [NIB_W-1:0] nib,
                                    input logic [HOLD_W:0] hold);
    pin_phase_t ph;
    ph.rs   = rs;
    ph.en   = en;
    ph.nib  = nib;
    ph.hold = hold[HOLD_W] ? {HOLD_W{1'b1}} : hold[HOLD_W-1:0];
    ph.last = 1'b0;
    phases_due.push_back(ph);
  endfunction

  function automatic void add_nibble(input logic rs, input logic [NIB_W-1:0] nib,
                                     input logic [HOLD_W:0] settle_hold);
    add_phase(rs, 1'b1, nib, {{(HOLD_W-WORD_W+1){1'b0}}, pulse_r});
    add_phase(rs, 1'b0, nib, settle_hold);
  endfunction

  function automatic void add_byte(input logic rs, input logic [WORD_W-1:0] word,
                                   input logic [HOLD_W:0] last_settle);
    add_nibble(rs, word[7:4], {1'b0, settle_r});
    add_nibble(rs, word[3:0], last_settle);
  endfunction

  function automatic void expand_command(input op_t op, input logic [WORD_W-1:0] data_val,
                                         input logic rs);
    logic [HOLD_W:0] settle_hold;
    settle_hold = {1'b0, settle_r};
    if (op == OP_WRITE) begin
      add_byte(rs, data_val, settle_hold);
    end else begin
      // register select and data are ignored during init
      add_phase(1'b0, 1'b0, 4'h0, {1'b0, power_wait_r});
      add_nibble(1'b0, WAKE_NIBBLE, {1'b0, INIT_SLOW_WAIT_US});
      add_nibble(1'b0, WAKE_NIBBLE, settle_hold);
      add_nibble(1'b0, WAKE_NIBBLE, settle_hold);
      add_nibble(1'b0, FOUR_BIT_NIBBLE, settle_hold);
      add_byte(1'b0, fset_word_r, settle_hold);
      add_byte(1'b0, CMD_DISPLAY_OFF, settle_hold);
      add_byte(1'b0, CMD_CLEAR, settle_hold + {1'b0, clear_extra_r});
      add_byte(1'b0, entry_word_r, settle_hold);
      add_byte(1'b0, don_word_r, settle_hold);
    end
    phases_due[phases_due.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [HOLD_W-1:0] want,
                                      input logic [HOLD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    pin_phase_t want;
    if (!rst_n) begin
      power_wait_r  <= RST_POWER_ON_WAIT;
      fset_word_r   <= RST_FUNCTION_SET;
      entry_word_r  <= RST_ENTRY_MODE;
      don_word_r    <= RST_DISPLAY_ON;
      settle_r      <= RST_SETTLE;
      clear_extra_r <= RST_CLEAR_EXTRA;
      pulse_r       <= RST_ENABLE_PULSE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POWER_ON_WAIT: power_wait_r  <= cfg_wdata;
          CFG_FUNCTION_SET:  fset_word_r   <= cfg_wdata[WORD_W-1:0];
          CFG_ENTRY_MODE:    entry_word_r  <= cfg_wdata[WORD_W-1:0];
          CFG_DISPLAY_ON:    don_word_r    <= cfg_wdata[WORD_W-1:0];
          CFG_SETTLE:        settle_r      <= cfg_wdata;
          CFG_CLEAR_EXTRA:   clear_extra_r <= cfg_wdata;
          CFG_ENABLE_PULSE:  pulse_r       <= cfg_wdata[WORD_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expand_command(op_t'(in_tuser[0]), in_tdata[7:0], in_tdata[8]);
      if (out_tvalid && out_tready) begin
        if (phases_due.size() == 0) begin
          $error("phase left the block with no command outstanding");
          errors++;
        end else begin
          want = phases_due.pop_front();
          check_field("rs_level", 16'(want.rs), 16'(out_tdata[0]));
          check_field("enable_level", 16'(want.en), 16'(out_tdata[1]));
          check_field("data_nibble", 16'(want.nib), 16'(out_tdata[5:2]));
          check_field("hold_us", want.hold, out_tdata[21:6]);
          check_field("last_phase", 16'(want.last), 16'(out_tlast));
        end
      end
    end
    pending = phases_due.size();
  end

endmodule

@@ tb/tb_char_lcd_4bit_write_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_write_sequencer_core
// Drives init and byte-write commands and register settings into the LCD
// write sequencer with random idling on both sides and one long output
// stall; the phase checker beside the block judges every phase.
// ----------------------------------------------------------------------------
module tb_char_lcd_4bit_write_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;  // not a register
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned QUIET_CYCLES     = 4;
  localparam int unsigned ITEMS_PER_ROUND  = 47;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [15:0]           in_tdata   = '0;   // data_byte[7:0], register_select[8]
  logic [0:0]            in_tuser   = '0;   // operation
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire  [23:0]           out_tdata;         // rs[0], enable[1], nibble[5:2], hold_us[21:6]
  wire                   out_tlast;
  int unsigned           errors;
  int unsigned           pending;

  // 0 turns idling off, otherwise a 1-in-N chance per item or cycle
  int unsigned send_idle_odds = 0;
  int unsigned recv_idle_odds = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served   = 0;

  always #1 clk = ~clk;

  char_lcd_4bit_write_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  clcd_phase_checker u_phase_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending)
  );

  task automatic send_cmd(input op_t op, input logic [7:0] data_val, input logic rs);
    if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, rs, data_val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_cmd();
    send_cmd(op_t'(($urandom_range(0, 9) == 0) ? OP_INIT : OP_WRITE),
             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // stop offering, let every phase out, then idle quietly before returning
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] power_wait, input logic [15:0] fset,
                             input logic [15:0] entry, input logic [15:0] don,
                             input logic [15:0] settle, input logic [15:0] clear_extra,
                             input logic [15:0] pulse);
    set_reg(CFG_POWER_ON_WAIT, power_wait);
    set_reg(CFG_FUNCTION_SET, fset);
    set_reg(CFG_ENTRY_MODE, entry);
    set_reg(CFG_DISPLAY_ON, don);
    set_reg(CFG_SETTLE, settle);
    set_reg(CFG_CLEAR_EXTRA, clear_extra);
    set_reg(CFG_ENABLE_PULSE, pulse);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] random_wait();
    return ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 300));
  endfunction

  initial begin : receiver
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults; init ignores the write fields
    send_cmd(OP_INIT, 8'hFF, 1'b1);
    send_cmd(OP_WRITE, 8'h00, 1'b0);
    send_cmd(OP_WRITE, 8'hFF, 1'b1);
    send_cmd(OP_WRITE, 8'hA5, 1'b0);
    send_cmd(OP_WRITE, 8'h5A, 1'b1);
    drain();

    // everything zero, including a zero-length enable pulse
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_cmd(OP_INIT, 8'h00, 1'b0);
    send_cmd(OP_WRITE, 8'h81, 1'b1);
    drain();

    // all ones: byte registers drop the top bits, clear settle saturates,
    // and a write to the spare index must change nothing
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_reg(CFG_NONE, 16'h0000);
    cfg_we <= 1'b0;
    send_cmd(OP_INIT, 8'h3C, 1'b1);
    send_cmd(OP_WRITE, 8'h7E, 1'b0);
    drain();

    // clear settle landing exactly on the maximum, then one past it
    load_config(16'd1, 16'h5500, 16'hAA, 16'h0F, 16'd60000, 16'd5535, 16'd255);
    send_cmd(OP_INIT, 8'h00, 1'b0);
    drain();
    load_config(16'd2, 16'h28, 16'h06, 16'h0F, 16'd60000, 16'd5536, 16'd1);
    send_cmd(OP_INIT, 8'h00, 1'b0);
    send_cmd(OP_WRITE, 8'hC3, 1'b1);
    drain();

    for (int round = 0; round < 8; round++) begin
      if (round == 0)
        load_config(RST_POWER_ON_WAIT, 16'(RST_FUNCTION_SET), 16'(RST_ENTRY_MODE),
                    16'(RST_DISPLAY_ON), RST_SETTLE, RST_CLEAR_EXTRA,
                    16'(RST_ENABLE_PULSE));
      else
        load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    random_wait(), random_wait(), 16'($urandom_range(0, 65535)));
      send_idle_odds = (round % 3 == 1) ? 0 : 3;
      recv_idle_odds = (round % 3 == 2) ? 0 : 4;
      if (round == 2) begin
        // sender keeps offering while the output is held off
        send_idle_odds = 0;
        stall_requests++;
      end
      if (round == 7) begin
        send_idle_odds = 0;
        recv_idle_odds = 0;
      end
      repeat (ITEMS_PER_ROUND) send_random_cmd();
      drain();
    end

    if (pending != 0)
      $error("%0d phases still outstanding at the end", pending);
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/clcd_pkg.sv
rtl/char_lcd_4bit_write_sequencer_core.sv
tb/clcd_phase_checker.sv
tb/tb_char_lcd_4bit_write_sequencer_core.sv
